@@ hw/rtl/lxrd_pkg.sv @@
// ----------------------------------------------------------------------------
// lxrd_pkg
// Shared types, constants and the block order table for the record decryptor.
// ----------------------------------------------------------------------------
`default_nettype none

package lxrd_pkg;

	localparam int unsigned RecWords    = 116;
	localparam int unsigned HdrWords    = 4;
	localparam int unsigned BlkWords    = 28;
	localparam int unsigned ShufCount   = 24;
	localparam int unsigned FifoDepthDef = 2;

	localparam logic [31:0] LcgMul = 32'h41C6_4E6D;
	localparam logic [31:0] LcgAdd = 32'h0000_6073;

	localparam logic [6:0] PosKeyLo  = 7'd0;
	localparam logic [6:0] PosKeyHi  = 7'd1;
	localparam logic [6:0] PosSanity = 7'd2;
	localparam logic [6:0] PosCheck  = 7'd3;
	localparam logic [6:0] PosLast   = 7'(RecWords - 1);
	localparam logic [4:0] OffLast   = 5'(BlkWords - 1);

	typedef enum logic [2:0] {
		KIND_KEY_LO  = 3'd0,
		KIND_KEY_HI  = 3'd1,
		KIND_SANITY  = 3'd2,
		KIND_CHECK   = 3'd3,
		KIND_PAYLOAD = 3'd4
	} lxrd_kind_t;

	typedef struct packed {
		logic [15:0] word;
		lxrd_kind_t  kind;
		logic [6:0]  dest;
		logic        last;
	} lxrd_entry_t;

	// Row per shuffle value: destination block of source block b in bits [2b+1:2b].
	localparam logic [7:0] ShufTbl [ShufCount] = '{
		8'hE4, 8'hB4, 8'hD8, 8'h78, 8'h9C, 8'h6C,
		8'hE1, 8'hB1, 8'hC9, 8'h39, 8'h8D, 8'h2D,
		8'hD2, 8'h72, 8'hC6, 8'h36, 8'h4E, 8'h1E,
		8'h93, 8'h63, 8'h87, 8'h27, 8'h4B, 8'h1B
	};

	function automatic logic [1:0] dest_block(input logic [4:0] sel, input logic [1:0] blk);
		logic [7:0] row;
		row = ShufTbl[sel];
		return row[{blk, 1'b0} +: 2];
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lcg_xor_record_decrypt_unshuffle.sv @@
// ----------------------------------------------------------------------------
// lcg_xor_record_decrypt_unshuffle
// Decrypts 116-word records against an LCG keystream and tags each word with
// its destination index after the block unshuffle.
// ----------------------------------------------------------------------------
// Takes one 16-bit word per cycle while in_ready is high and returns one
// result per word, in order. Words 0 and 1 carry the key, words 2 and 3 the
// sanity word and checksum; each later word is XORed with the top half of the
// keystream, and the last word of a record reports record_valid. A result
// passes the FIFO and the output register; the sustained rate is one word per
// cycle while out_ready stays high, with the keystream from the single 32-bit
// multiply-add in the back end. The first word after reset starts a record.
`default_nettype none

module lcg_xor_record_decrypt_unshuffle import lxrd_pkg::*; #(
	parameter int unsigned FifoDepth = FifoDepthDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] word_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      word_out,
	output logic [6:0]       dest_index,
	output logic             last,
	output logic             record_valid
);

	lxrd_entry_t push_data;
	lxrd_entry_t pop_data;
	logic        push;
	logic        pop;
	logic        q_full;
	logic        q_not_empty;

	lxrd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.word_in   (word_in),
		.q_full    (q_full),
		.in_ready  (in_ready),
		.push      (push),
		.push_data (push_data)
	);

	lxrd_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop_data  (pop_data)
	);

	lxrd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_data       (pop_data),
		.pop          (pop),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.word_out     (word_out),
		.dest_index   (dest_index),
		.last         (last),
		.record_valid (record_valid)
	);

endmodule

`default_nettype wire

@@ hw/rtl/lxrd_front.sv @@
// ----------------------------------------------------------------------------
// lxrd_front
// Tracks the word position, extracts the shuffle value and tags each word
// with its kind and unshuffled destination index.
// ----------------------------------------------------------------------------
`default_nettype none

module lxrd_front import lxrd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [15:0] word_in,
	input  wire logic        q_full,
	output logic             in_ready,
	output logic             push,
	output lxrd_entry_t      push_data
);

	logic [6:0] pos_q;
	logic [1:0] blk_q;
	logic [4:0] off_q;
	logic [2:0] key_mid_q;
	logic [4:0] sel_q;
	logic [4:0] sel_raw;
	logic [4:0] sel_mod;
	logic [6:0] payload_dest;
	logic       is_last;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign is_last  = (pos_q == PosLast);

	assign sel_raw = {word_in[1:0], key_mid_q};
	assign sel_mod = (sel_raw >= 5'(ShufCount)) ? sel_raw - 5'(ShufCount) : sel_raw;

	assign payload_dest = 7'(HdrWords) + 7'(BlkWords) * {5'd0, dest_block(sel_q, blk_q)}
		+ {2'd0, off_q};

	always_comb begin
		push_data.word = word_in;
		push_data.dest = pos_q;
		push_data.last = 1'b0;
		unique case (pos_q)
			PosKeyLo:  push_data.kind = KIND_KEY_LO;
			PosKeyHi:  push_data.kind = KIND_KEY_HI;
			PosSanity: push_data.kind = KIND_SANITY;
			PosCheck:  push_data.kind = KIND_CHECK;
			default: begin
				push_data.kind = KIND_PAYLOAD;
				push_data.dest = payload_dest;
				push_data.last = is_last;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			blk_q     <= '0;
			off_q     <= '0;
			key_mid_q <= '0;
			sel_q     <= '0;
		end else if (push) begin
			pos_q <= is_last ? '0 : pos_q + 7'd1;
			if (pos_q == PosKeyLo) begin
				key_mid_q <= word_in[15:13];
			end
			if (pos_q == PosKeyHi) begin
				sel_q <= sel_mod;
			end
			if (push_data.kind == KIND_PAYLOAD) begin
				if (is_last) begin
					blk_q <= '0;
					off_q <= '0;
				end else if (off_q == OffLast) begin
					blk_q <= blk_q + 2'd1;
					off_q <= '0;
				end else begin
					off_q <= off_q + 5'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/lxrd_fifo.sv @@
// ----------------------------------------------------------------------------
// lxrd_fifo
// Short queue of tagged words between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lxrd_fifo import lxrd_pkg::*; #(
	parameter int unsigned Depth = FifoDepthDef
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire lxrd_entry_t  push_data,
	input  wire logic         pop,
	output logic              full,
	output logic              not_empty,
	output lxrd_entry_t       pop_data
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	lxrd_entry_t          mem_q [Depth];
	logic [PtrW-1:0]      wr_ptr_q;
	logic [PtrW-1:0]      rd_ptr_q;
	logic [CntW-1:0]      count_q;

	assign full      = (count_q == CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/lxrd_back.sv @@
// ----------------------------------------------------------------------------
// lxrd_back
// Runs the keystream, decrypts payload words, accumulates the checksum and
// holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lxrd_back import lxrd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_not_empty,
	input  wire lxrd_entry_t q_data,
	output logic             pop,
	input  wire logic        out_ready,
	output logic             out_valid,
	output logic [15:0]      word_out,
	output logic [6:0]       dest_index,
	output logic             last,
	output logic             record_valid
);

	logic [31:0] seed_q;
	logic [15:0] sum_q;
	logic [15:0] exp_q;
	logic        bad_q;
	logic        out_valid_q;
	logic [15:0] word_q;
	logic [6:0]  dest_q;
	logic        last_q;
	logic        rv_q;

	logic [31:0] seed_next;
	logic [15:0] res;
	logic [15:0] sum_next;
	logic        is_payload;

	assign pop        = q_not_empty && (!out_valid_q || out_ready);
	assign is_payload = (q_data.kind == KIND_PAYLOAD);
	assign seed_next  = seed_q * LcgMul + LcgAdd;
	assign res        = is_payload ? (q_data.word ^ seed_q[31:16]) : q_data.word;
	assign sum_next   = sum_q + res;

	assign out_valid    = out_valid_q;
	assign word_out     = word_q;
	assign dest_index   = dest_q;
	assign last         = last_q;
	assign record_valid = rv_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= res;
			dest_q <= q_data.dest;
			last_q <= q_data.last;
			rv_q   <= q_data.last && !bad_q && (sum_next == exp_q);
		end
	end

	// seed is advanced once on the sanity word so it leads each payload word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			seed_q      <= '0;
			sum_q       <= '0;
			exp_q       <= '0;
			bad_q       <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				unique case (q_data.kind)
					KIND_KEY_LO: begin
						seed_q[15:0] <= q_data.word;
						sum_q        <= '0;
					end
					KIND_KEY_HI: begin
						seed_q[31:16] <= q_data.word;
					end
					KIND_SANITY: begin
						bad_q  <= |q_data.word;
						seed_q <= seed_next;
					end
					KIND_CHECK: begin
						exp_q <= q_data.word;
					end
					KIND_PAYLOAD: begin
						seed_q <= seed_next;
						sum_q  <= sum_next;
					end
					default: begin
						seed_q <= seed_q;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/lxrd_checker.sv @@
// ----------------------------------------------------------------------------
// lxrd_checker
// Port-level checks on the record decryptor's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module lxrd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] word_out,
	input wire logic [6:0]  dest_index,
	input wire logic        last,
	input wire logic        record_valid
);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(word_out) && $stable(dest_index)
			&& $stable(last) && $stable(record_valid))
		else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_valid |-> last)
		else $error("record_valid away from last word");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> dest_index == 7'd31 || dest_index == 7'd59
			|| dest_index == 7'd87 || dest_index == 7'd115)
		else $error("last word not at end of a block");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> dest_index <= 7'd115)
		else $error("dest_index out of record");

endmodule

bind lcg_xor_record_decrypt_unshuffle lxrd_checker u_lxrd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.word_out     (word_out),
	.dest_index   (dest_index),
	.last         (last),
	.record_valid (record_valid)
);

`default_nettype wire
